// ===== rtl/ntrl_pkg.sv =====
// Shared types, constants and helpers for the neighbor table with recent list.
// Used by the top level, the recent-list unit and the port checker.
package ntrl_pkg;

  localparam int unsigned AddrW    = 48;
  localparam int unsigned TotalW   = 7;
  localparam int unsigned InclW    = 2;
  localparam int unsigned AlenW    = 5;
  localparam int unsigned RecCntW  = 2;

  localparam int unsigned NEIGHBOR_MAX_DEF = 64;
  localparam int unsigned RECENT_MAX_DEF   = 3;

  // advert payload bookkeeping: length counted from the fixed header offsets
  localparam int unsigned APP_BASE_OFFSET = 11;
  localparam int unsigned APP_ADDR_OFFSET = 13;
  localparam int unsigned ADDR_BYTES      = 6;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_DONE   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             req_type;
    logic [AddrW-1:0] peer_address;
  } in_beat_t;

  typedef struct packed {
    logic              added_new;
    logic              store_full;
    logic [TotalW-1:0] neighbor_total;
    logic [InclW-1:0]  included_count;
    logic [AlenW-1:0]  app_length;
    logic [AddrW-1:0]  recent_address;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    logic               upd;
    logic [AddrW-1:0]   addr;
    logic [RecCntW-1:0] rd_idx;
  } rec_req_t;

  function automatic logic [AlenW-1:0] app_len(input logic [InclW-1:0] n);
    int unsigned len;
    len = APP_ADDR_OFFSET + ADDR_BYTES * int'(n) - APP_BASE_OFFSET;
    return len[AlenW-1:0];
  endfunction

endpackage

// ===== rtl/ntrl_recent.sv =====
// Most-recent address list with move-to-front update and one read port.
// Depends on ntrl_pkg for widths and the request struct.
module ntrl_recent #(
  parameter int unsigned RECENT_MAX = ntrl_pkg::RECENT_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ntrl_pkg::rec_req_t               req_i,
  output logic [ntrl_pkg::AddrW-1:0]       rd_addr_o,
  output logic [ntrl_pkg::RecCntW-1:0]     fill_o
);

  localparam int unsigned RecIdxW = (RECENT_MAX > 1) ? $clog2(RECENT_MAX) : 1;

  logic [ntrl_pkg::AddrW-1:0]   list_q [RECENT_MAX];
  logic [ntrl_pkg::AddrW-1:0]   list_d [RECENT_MAX];
  logic [ntrl_pkg::RecCntW-1:0] fill_q, fill_d;
  logic [ntrl_pkg::RecCntW-1:0] pos;
  logic                         hit;

  always_comb begin
    hit    = 1'b0;
    pos    = fill_q;
    fill_d = fill_q;
    for (int i = 0; i < RECENT_MAX; i++) begin
      if (!hit && (ntrl_pkg::RecCntW'(i) < fill_q) && (list_q[i] == req_i.addr)) begin
        hit = 1'b1;
        pos = ntrl_pkg::RecCntW'(i);
      end
    end
    if (!hit) begin
      if (fill_q < ntrl_pkg::RecCntW'(RECENT_MAX)) begin
        fill_d = fill_q + 1'b1;
        pos    = fill_q;
      end else begin
        pos = ntrl_pkg::RecCntW'(RECENT_MAX - 1);
      end
    end
    // shift everything above the hit slot down by one, new address on top
    list_d[0] = req_i.addr;
    for (int i = 1; i < RECENT_MAX; i++) begin
      if (ntrl_pkg::RecCntW'(i) <= pos) begin
        list_d[i] = list_q[i-1];
      end else begin
        list_d[i] = list_q[i];
      end
    end
    if (!req_i.upd) begin
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.upd) begin
      for (int i = 0; i < RECENT_MAX; i++) begin
        list_q[i] <= list_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign rd_addr_o = list_q[req_i.rd_idx[RecIdxW-1:0]];
  assign fill_o    = fill_q;

endmodule

// ===== rtl/neighbor_table_with_recent_list.sv =====
// Top level: neighbor store with sequential lookup and the recent-list summary.
// Depends on ntrl_pkg and ntrl_recent.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one beat per
//   request. req_type = report looks peer_address up in the store, appends it
//   if unknown and there is room, and, if it is now held, moves it to the front of the recent list.
//   req_type = done emits a header beat followed by the recent addresses,
//   newest first; last marks the final beat of each request.
//   Output channel (out_valid_o / out_stall_i / out_data_o): beats are held
//   stable while out_stall_i is high; the block waits and does nothing else.
// Timing:
//   A report walks the store through one shared 48-bit comparator, one entry
//   per cycle off the registered memory read, then passes the decide state
//   on to its result beat, which waits out any output stall.
//   A summary goes straight to output: 1 + recent fill beats, one per cycle unless stalled.
//   in_stall_o is high from accept until the last result beat is taken.
// Reset: fill counts of the store and the recent list clear to zero at once;
//   the store memory itself is not cleared, no sweep is needed.
module neighbor_table_with_recent_list #(
  parameter int unsigned NEIGHBOR_MAX = ntrl_pkg::NEIGHBOR_MAX_DEF,
  parameter int unsigned RECENT_MAX   = ntrl_pkg::RECENT_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ntrl_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ntrl_pkg::out_beat_t  out_data_o
);

  localparam int unsigned CntW = $clog2(NEIGHBOR_MAX + 1);
  localparam int unsigned IdxW = (NEIGHBOR_MAX > 1) ? $clog2(NEIGHBOR_MAX) : 1;

  ntrl_pkg::state_e state_q, state_d;

  logic                          req_q, req_d;
  logic [ntrl_pkg::AddrW-1:0]    addr_q, addr_d;
  logic [CntW-1:0]               ptr_q, ptr_d;
  logic [CntW-1:0]               fill_q, fill_d;
  logic                          found_q, found_d;
  logic                          added_q, added_d;
  logic                          full_q, full_d;
  logic [ntrl_pkg::RecCntW-1:0]  beat_q, beat_d;

  logic [ntrl_pkg::AddrW-1:0]    mem [NEIGHBOR_MAX];
  logic [ntrl_pkg::AddrW-1:0]    rd_q;
  logic                          rd_en;
  logic [IdxW-1:0]               rd_idx;
  logic                          mem_we;

  logic                          accept;
  logic                          match;
  logic                          last_beat;
  logic [CntW+ntrl_pkg::TotalW-1:0] total_ext;

  ntrl_pkg::rec_req_t            rec_req;
  logic [ntrl_pkg::AddrW-1:0]    rec_addr;
  logic [ntrl_pkg::RecCntW-1:0]  rec_fill;

  assign accept    = in_valid_i && (state_q == ntrl_pkg::ST_IDLE);
  assign match     = (rd_q == addr_q);
  assign last_beat = (req_q == ntrl_pkg::REQ_REPORT) || (beat_q == rec_fill);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ntrl_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data_i.req_type == ntrl_pkg::REQ_DONE) begin
            state_d = ntrl_pkg::ST_EMIT;
          end else if (fill_q == '0) begin
            state_d = ntrl_pkg::ST_DECIDE;
          end else begin
            state_d = ntrl_pkg::ST_SCAN;
          end
        end
      end
      ntrl_pkg::ST_SCAN: begin
        if (match || (ptr_q == fill_q)) begin
          state_d = ntrl_pkg::ST_DECIDE;
        end
      end
      ntrl_pkg::ST_DECIDE: begin
        state_d = ntrl_pkg::ST_EMIT;
      end
      ntrl_pkg::ST_EMIT: begin
        if (!out_stall_i && last_beat) begin
          state_d = ntrl_pkg::ST_IDLE;
        end
      end
      default: state_d = ntrl_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    req_d          = req_q;
    addr_d         = addr_q;
    ptr_d          = ptr_q;
    fill_d         = fill_q;
    found_d        = found_q;
    added_d        = added_q;
    full_d         = full_q;
    beat_d         = beat_q;
    rd_en          = 1'b0;
    rd_idx         = ptr_q[IdxW-1:0];
    mem_we         = 1'b0;
    rec_req.upd    = 1'b0;
    rec_req.addr   = addr_q;
    rec_req.rd_idx = beat_q - 1'b1;
    case (state_q)
      ntrl_pkg::ST_IDLE: begin
        if (accept) begin
          req_d   = in_data_i.req_type;
          addr_d  = in_data_i.peer_address;
          found_d = 1'b0;
          added_d = 1'b0;
          full_d  = 1'b0;
          beat_d  = '0;
          if (in_data_i.req_type == ntrl_pkg::REQ_REPORT && fill_q != '0) begin
            rd_en  = 1'b1;
            rd_idx = '0;
            ptr_d  = CntW'(1);
          end
        end
      end
      ntrl_pkg::ST_SCAN: begin
        found_d = match;
        if (!match && ptr_q != fill_q) begin
          rd_en = 1'b1;
          ptr_d = ptr_q + 1'b1;
        end
      end
      ntrl_pkg::ST_DECIDE: begin
        if (found_q) begin
          rec_req.upd = 1'b1;
        end else if (fill_q != CntW'(NEIGHBOR_MAX)) begin
          mem_we      = 1'b1;
          fill_d      = fill_q + 1'b1;
          added_d     = 1'b1;
          rec_req.upd = 1'b1;
        end else begin
          full_d = 1'b1;
        end
      end
      ntrl_pkg::ST_EMIT: begin
        if (!out_stall_i) begin
          beat_d = beat_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntrl_pkg::ST_IDLE;
      fill_q  <= '0;
      ptr_q   <= '0;
      beat_q  <= '0;
      req_q   <= ntrl_pkg::REQ_REPORT;
      found_q <= 1'b0;
      added_q <= 1'b0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ptr_q   <= ptr_d;
      beat_q  <= beat_d;
      req_q   <= req_d;
      found_q <= found_d;
      added_q <= added_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  // neighbor store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[fill_q[IdxW-1:0]] <= addr_q;
    end
    if (rd_en) begin
      rd_q <= mem[rd_idx];
    end
  end

  ntrl_recent #(
    .RECENT_MAX (RECENT_MAX)
  ) u_recent (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rec_req),
    .rd_addr_o (rec_addr),
    .fill_o    (rec_fill)
  );

  assign total_ext = {{ntrl_pkg::TotalW{1'b0}}, fill_q};

  always_comb begin
    out_data_o                = '0;
    out_data_o.neighbor_total = total_ext[ntrl_pkg::TotalW-1:0];
    out_data_o.last           = last_beat;
    if (req_q == ntrl_pkg::REQ_REPORT) begin
      out_data_o.added_new  = added_q;
      out_data_o.store_full = full_q;
    end else begin
      out_data_o.included_count = rec_fill;
      out_data_o.app_length     = ntrl_pkg::app_len(rec_fill);
      if (beat_q != '0) begin
        out_data_o.recent_address = rec_addr;
      end
    end
  end

  assign out_valid_o = (state_q == ntrl_pkg::ST_EMIT);
  assign in_stall_o  = (state_q != ntrl_pkg::ST_IDLE);

endmodule

// ===== rtl/ntrl_checker.sv =====
// Port-level checker for the neighbor table, bound to the top level.
// Depends on ntrl_pkg for the beat structs.
module ntrl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ntrl_pkg::in_beat_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ntrl_pkg::out_beat_t out_data_o
);

  // no new request is taken while a result beat is pending
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while output beat pending");

  // one request at a time
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block ready right after accepting a beat");

  // report results flagging a new entry or a full store are single beats with no recent address or count
  a_report_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.added_new || out_data_o.store_full)) |->
      (out_data_o.last && !(out_data_o.added_new && out_data_o.store_full) &&
       out_data_o.recent_address == '0 && out_data_o.included_count == '0))
    else $error("malformed report result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed");

endmodule

bind neighbor_table_with_recent_list ntrl_checker u_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for neighbor_table_with_recent_list: directed beats, then random
// report/summary traffic under changing idle and stall rates. Depends on ntrl_pkg and the RTL.
module testbench;
  import ntrl_pkg::*;

  localparam int unsigned NBR_MAX   = NEIGHBOR_MAX_DEF;
  localparam int unsigned MRU_MAX   = RECENT_MAX_DEF;
  localparam int unsigned HOLD_LEN  = 400;   // long receiver hold-off
  localparam int unsigned DOG_LIMIT = 3000;  // cycles with no beat on either side
  localparam int unsigned TAIL      = 80;    // longer than the worst report latency
  localparam int unsigned PHASE_LEN = 38;

  typedef struct {
    in_beat_t  req;
    bit        typed;
    out_beat_t exp;
  } probe_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  // shadow copy of the table
  logic [AddrW-1:0] nbr_store [NBR_MAX];
  int unsigned      nbr_fill;
  logic [AddrW-1:0] mru [MRU_MAX];
  int unsigned      mru_fill;

  out_beat_t   replies_due [$];
  probe_row_t  probe_tab [$];
  int unsigned idle_pct, stall_pct;
  bit          pressure_on, pressure_done;
  int unsigned hold_cnt, dog_cnt;
  int unsigned errors, n_sent, n_beats, n_full, n_summaries;

  neighbor_table_with_recent_list #(
    .NEIGHBOR_MAX(NBR_MAX),
    .RECENT_MAX  (MRU_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void promote(input logic [AddrW-1:0] a);
    int unsigned pos;
    pos = mru_fill;
    for (int unsigned i = 0; i < mru_fill; i++) begin
      if (mru[i] == a) begin
        pos = i;
        break;
      end
    end
    if (pos >= mru_fill) begin
      if (mru_fill < MRU_MAX) mru_fill++;
      pos = mru_fill - 1;
    end
    for (int unsigned i = pos; i > 0; i--) mru[i] = mru[i-1];
    mru[0] = a;
  endfunction

  // expected beats for one accepted request; updates the shadow table
  function automatic void table_reply(input in_beat_t b);
    out_beat_t   r;
    logic        hit;
    int unsigned alen;
    r   = '0;
    hit = 1'b0;
    if (b.req_type == REQ_REPORT) begin
      for (int unsigned i = 0; i < nbr_fill; i++)
        if (nbr_store[i] == b.peer_address) hit = 1'b1;
      if (!hit && nbr_fill < NBR_MAX) begin
        nbr_store[nbr_fill] = b.peer_address;
        nbr_fill++;
        r.added_new = 1'b1;
      end else if (!hit) begin
        r.store_full = 1'b1;
        n_full++;
      end
      if (!r.store_full) promote(b.peer_address);
      r.neighbor_total = TotalW'(nbr_fill);
      r.last           = 1'b1;
      replies_due.push_back(r);
    end else begin
      n_summaries++;
      alen             = APP_ADDR_OFFSET + ADDR_BYTES * mru_fill - APP_BASE_OFFSET;
      r.neighbor_total = TotalW'(nbr_fill);
      r.included_count = InclW'(mru_fill);
      r.app_length     = AlenW'(alen);
      r.last           = (mru_fill == 0);
      replies_due.push_back(r);
      for (int unsigned k = 0; k < mru_fill; k++) begin
        r.recent_address = mru[k];
        r.last           = (k + 1 == mru_fill);
        replies_due.push_back(r);
      end
    end
  endfunction

  // mostly known or fresh addresses; near misses hit the comparator one bit off
  function automatic in_beat_t pick_request();
    in_beat_t    b;
    int unsigned roll;
    b.req_type     = REQ_REPORT;
    b.peer_address = AddrW'({$urandom(), $urandom()});
    roll           = $urandom_range(99);
    if (roll < 12) begin
      b.req_type = REQ_DONE;
    end else if (roll < 12 + ((nbr_fill < NBR_MAX) ? 50 : 28)) begin
      if (nbr_fill != 0 && $urandom_range(3) == 0)
        b.peer_address = nbr_store[$urandom_range(nbr_fill - 1)]
                         ^ (48'd1 << $urandom_range(AddrW - 1));
    end else if (nbr_fill != 0) begin
      if (mru_fill != 0 && $urandom_range(2) == 0)
        b.peer_address = mru[$urandom_range(mru_fill - 1)];
      else
        b.peer_address = nbr_store[$urandom_range(nbr_fill - 1)];
    end
    return b;
  endfunction

  function automatic string beat_str(input out_beat_t x);
    return $sformatf("new=%0d full=%0d total=%0d incl=%0d len=%0d addr=%012h last=%0d",
                     x.added_new, x.store_full, x.neighbor_total, x.included_count,
                     x.app_length, x.recent_address, x.last);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // valid stays high between back-to-back beats; only dropped for a gap
  task automatic offer(input in_beat_t b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    table_reply(b);
    n_sent++;
  endtask

  initial begin : receiver
    out_stall_i   = 1'b0;
    pressure_done = 1'b0;
    hold_cnt      = 0;
    forever begin
      @(posedge clk_i);
      if (pressure_on && !pressure_done) begin
        out_stall_i <= 1'b1;
        hold_cnt++;
        if (hold_cnt == HOLD_LEN) pressure_done = 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_beats++;
      if (replies_due.size() == 0) begin
        flag_error({"result beat with nothing expected: ", beat_str(out_data_o)});
      end else begin
        want = replies_due.pop_front();
        if (out_data_o.added_new      !== want.added_new      ||
            out_data_o.store_full     !== want.store_full     ||
            out_data_o.neighbor_total !== want.neighbor_total ||
            out_data_o.included_count !== want.included_count ||
            out_data_o.app_length     !== want.app_length     ||
            out_data_o.recent_address !== want.recent_address ||
            out_data_o.last           !== want.last)
          flag_error({"result beat mismatch\n  expected ", beat_str(want),
                      "\n  actual   ", beat_str(out_data_o)});
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      dog_cnt <= 0;
    end else if (dog_cnt == DOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d beats outstanding",
               DOG_LIMIT, replies_due.size());
      $display("testbench: FAIL");
      $finish;
    end else begin
      dog_cnt <= dog_cnt + 1;
    end
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    pressure_on = 1'b0;
    nbr_fill    = 0;
    mru_fill    = 0;
    errors      = 0;
    n_sent      = 0;
    n_beats     = 0;
    n_full      = 0;
    n_summaries = 0;

    // summary on an empty list, address field ignored
    probe_tab.push_back('{'{REQ_DONE, '1}, 1'b1, '{1'b0, 1'b0, 7'd0, 2'd0, 5'd2, 48'd0, 1'b1}});
    probe_tab.push_back('{'{REQ_REPORT, 48'h0}, 1'b1,
                          '{1'b1, 1'b0, 7'd1, 2'd0, 5'd0, 48'd0, 1'b1}});
    probe_tab.push_back('{'{REQ_DONE, 48'h0}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_REPORT, '1}, 1'b1,
                          '{1'b1, 1'b0, 7'd2, 2'd0, 5'd0, 48'd0, 1'b1}});
    // known address: no new entry, moves to front
    probe_tab.push_back('{'{REQ_REPORT, 48'h0}, 1'b1,
                          '{1'b0, 1'b0, 7'd2, 2'd0, 5'd0, 48'd0, 1'b1}});
    probe_tab.push_back('{'{REQ_DONE, 48'h0}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_REPORT, 48'h0000_0000_0001}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_REPORT, 48'h8000_0000_0000}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_DONE, 48'h0}, 1'b0, '0});
    // known but already dropped from the list, then two hits at the end and one at the front
    probe_tab.push_back('{'{REQ_REPORT, '1}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_REPORT, 48'h0000_0000_0001}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_REPORT, 48'h8000_0000_0000}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_REPORT, 48'h8000_0000_0000}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_DONE, 48'h0}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_REPORT, 48'h5555_5555_5555}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_REPORT, 48'hAAAA_AAAA_AAAA}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_REPORT, 48'h0000_0000_0002}, 1'b0, '0});
    probe_tab.push_back('{'{REQ_DONE, 48'h1234_5678_9ABC}, 1'b0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_tab[i]) begin
      offer(probe_tab[i].req);
      if (probe_tab[i].typed) replies_due[replies_due.size() - 1] = probe_tab[i].exp;
    end

    // no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 35 : 0;
      stall_pct = (ph == 2) ? 64 : (ph == 3) ? 35 : 0;
      repeat (PHASE_LEN) offer(pick_request());
    end

    // receiver holds off while requests keep coming: input must back up
    idle_pct    = 0;
    stall_pct   = 0;
    pressure_on = 1'b1;
    repeat (8) offer(pick_request());
    in_valid_i <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (replies_due.size() != 0) flag_error("expected beats never arrived");

    $display("run covered: %0d requests, %0d result beats, %0d summaries, %0d rejected",
             n_sent, n_beats, n_summaries, n_full);
    $display("  (store full), final fill %0d of %0d, %0d mismatches", nbr_fill, NBR_MAX, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
